FILE: rtl/level_bar_fall_and_peak_hold_macros.svh
// Assertion macros for the level meter.
`ifndef LEVEL_BAR_FALL_AND_PEAK_HOLD_MACROS_SVH
`define LEVEL_BAR_FALL_AND_PEAK_HOLD_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define LBFPH_ASSERT_SAME(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error("level meter check failed in the same cycle");

// Checks that a condition holds in the cycle after its trigger.
`define LBFPH_ASSERT_NEXT(label, clk, rstn, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("level meter check failed one cycle later");

`endif

FILE: rtl/lbfph_pkg.sv
package lbfph_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    localparam int LED_W      = 8;
    localparam int PCT_W      = 8;
    localparam int PCT_CLAMP_W = 7;
    localparam int PROD_W     = LED_W + PCT_CLAMP_W;
    localparam int STEP_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int DIV_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [PCT_CLAMP_W-1:0] PERCENT_MAX = 7'd100;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 2^15.
    localparam int            RECIP_W   = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int            RECIP_SHIFT = 19;

    localparam logic [DIV_W-1:0] FALL_DIVIDE = 3'd5;

    localparam logic [LED_W-1:0]  LED_COUNT_RESET     = 8'd10;
    localparam logic [STEP_W-1:0] FALL_STEP_RESET     = 8'd5;
    localparam logic [HOLD_W-1:0] PEAK_HOLD_RESET     = 16'd250;
    localparam logic [HOLD_W-1:0] PEAK_INTERVAL_RESET = 16'd500;

    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_LEVEL = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LED_COUNT    = 2'd0,
        CFG_FALL_STEP_MS = 2'd1,
        CFG_PEAK_HOLD_MS = 2'd2
    } cfg_index_t;

endpackage

FILE: rtl/level_bar_fall_and_peak_hold.sv
// An accepted input transaction reaches its result through the s1, s2 and output registers.
// Throughput: one transaction per cycle while m_axis_tready does not stall the output; scaling
// is split over two stages (product, then reciprocal multiply) ahead of the state update stage.
// Reset (aresetn low, synchronous) empties the pipeline, loads the register
// defaults and clears the meter state, with the peak interval at 500 ms.
`include "level_bar_fall_and_peak_hold_macros.svh"

module level_bar_fall_and_peak_hold import lbfph_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PCT_W-1:0]      s_axis_tdata,   // [7:0] level_percent
    input  logic                  s_axis_tuser,   // [0] req_type

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] bar_length, [15:8] peak_level,
                                                  // [16] falling, [23:17] zero
);

    logic [LED_W-1:0]  led_count_reg;
    logic [STEP_W-1:0] fall_step_reg;
    logic [HOLD_W-1:0] peak_hold_reg;

    logic                 s1_valid_reg;
    req_type_t            s1_type_reg;
    logic [PROD_W-1:0]    s1_prod_reg;
    logic                 s2_valid_reg;
    req_type_t            s2_type_reg;
    logic [LED_W-1:0]     s2_bar_reg;
    logic                 out_valid_reg;
    logic [LED_W-1:0]     out_bar_reg;
    logic [LED_W-1:0]     out_peak_reg;
    logic                 out_fall_reg;

    logic [LED_W-1:0]      bar_reg, bar_next;
    logic [LED_W-1:0]      peak_reg, peak_next;
    logic                  anim_active_reg, anim_active_next;
    logic [LED_W-1:0]      anim_position_reg, anim_position_next;
    logic [LED_W-1:0]      anim_start_reg, anim_start_next;
    logic [LED_W-1:0]      anim_target_reg, anim_target_next;
    logic [DIV_W-1:0]      step_divider_reg, step_divider_next;
    logic [HOLD_W-1:0]     peak_interval_reg, peak_interval_next;
    logic [TIMER_BITS-1:0] anim_timer_reg, anim_timer_next;
    logic [TIMER_BITS-1:0] peak_timer_reg, peak_timer_next;

    logic out_ready, s2_ready, s1_ready, s2_fire;
    logic [PCT_CLAMP_W-1:0] pct_clamped;
    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [HOLD_W+1:0] interval_x3;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign s2_fire       = s2_valid_reg && out_ready;

    assign pct_clamped = (s_axis_tdata > PCT_W'(PERCENT_MAX)) ? PERCENT_MAX
                                                              : s_axis_tdata[PCT_CLAMP_W-1:0];
    assign quot_full   = PROD_W'(s1_prod_reg) * RECIP_100;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-2*LED_W-1){1'b0}}, out_fall_reg, out_peak_reg,
                            out_bar_reg};

    always_comb begin
        logic [LED_W-1:0]      bar_in;
        logic                  start;
        logic [LED_W-1:0]      target1, start1, pos;
        logic [DIV_W-1:0]      div;
        logic                  act;
        logic [TIMER_BITS-1:0] atimer;
        logic [LED_W-1:0]      bar_out;
        logic [LED_W-1:0]      pk;
        logic [HOLD_W-1:0]     intv;
        logic [TIMER_BITS-1:0] ptimer;

        bar_in = anim_active_reg ? bar_reg : s2_bar_reg;
        start  = !anim_active_reg && (bar_in < bar_reg);
        act     = anim_active_reg || start;
        target1 = start ? bar_in : anim_target_reg;
        start1  = start ? bar_reg : anim_start_reg;
        pos     = start ? bar_reg : anim_position_reg;
        atimer  = start ? '0 : anim_timer_reg;
        div     = step_divider_reg;
        interval_x3 = {2'b00, peak_interval_reg} + {1'b0, peak_interval_reg, 1'b0};

        if (act && (CMP_BITS'(atimer) > CMP_BITS'(fall_step_reg))) begin
            if ((target1 < start1) && ((div == '0) || (div == FALL_DIVIDE))) begin
                pos = pos - 1'b1;
                div = '0;
            end
            div = div + 1'b1;
            if (pos == target1) begin
                act = 1'b0;
            end
            atimer = '0;
        end
        bar_out = act ? pos : bar_in;

        pk     = peak_reg;
        intv   = peak_interval_reg;
        ptimer = peak_timer_reg;
        if ((CMP_BITS'(ptimer) > CMP_BITS'(intv)) && (pk > LED_W'(1))) begin
            intv   = interval_x3[HOLD_W+1:2];
            pk     = pk - 1'b1;
            ptimer = '0;
        end
        if (pk <= bar_out) begin
            pk   = bar_out;
            intv = peak_hold_reg;
        end

        if (s2_type_reg == REQ_LEVEL) begin
            bar_next           = bar_out;
            peak_next          = pk;
            anim_active_next   = act;
            anim_position_next = pos;
            anim_start_next    = start1;
            anim_target_next   = target1;
            step_divider_next  = div;
            peak_interval_next = intv;
            anim_timer_next    = atimer;
            peak_timer_next    = ptimer;
        end else begin
            bar_next           = bar_reg;
            peak_next          = peak_reg;
            anim_active_next   = anim_active_reg;
            anim_position_next = anim_position_reg;
            anim_start_next    = anim_start_reg;
            anim_target_next   = anim_target_reg;
            step_divider_next  = step_divider_reg;
            peak_interval_next = peak_interval_reg;
            anim_timer_next    = (&anim_timer_reg) ? anim_timer_reg : anim_timer_reg + 1'b1;
            peak_timer_next    = (&peak_timer_reg) ? peak_timer_reg : peak_timer_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= LED_COUNT_RESET;
            fall_step_reg <= FALL_STEP_RESET;
            peak_hold_reg <= PEAK_HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LED_COUNT:    led_count_reg <= cfg_wdata[LED_W-1:0];
                CFG_FALL_STEP_MS: fall_step_reg <= cfg_wdata[STEP_W-1:0];
                CFG_PEAK_HOLD_MS: peak_hold_reg <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s_axis_tvalid) begin
            s1_type_reg <= req_type_t'(s_axis_tuser);
            s1_prod_reg <= led_count_reg * pct_clamped;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_type_reg <= s1_type_reg;
            s2_bar_reg  <= quot_full[RECIP_SHIFT +: LED_W];
        end
        if (s2_fire) begin
            out_bar_reg  <= bar_next;
            out_peak_reg <= peak_next;
            out_fall_reg <= anim_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_reg           <= '0;
            peak_reg          <= '0;
            anim_active_reg   <= 1'b0;
            anim_position_reg <= '0;
            anim_start_reg    <= '0;
            anim_target_reg   <= '0;
            step_divider_reg  <= '0;
            peak_interval_reg <= PEAK_INTERVAL_RESET;
            anim_timer_reg    <= '0;
            peak_timer_reg    <= '0;
        end else if (s2_fire) begin
            bar_reg           <= bar_next;
            peak_reg          <= peak_next;
            anim_active_reg   <= anim_active_next;
            anim_position_reg <= anim_position_next;
            anim_start_reg    <= anim_start_next;
            anim_target_reg   <= anim_target_next;
            step_divider_reg  <= step_divider_next;
            peak_interval_reg <= peak_interval_next;
            anim_timer_reg    <= anim_timer_next;
            peak_timer_reg    <= peak_timer_next;
        end
    end

    // While a fall runs, its position lies strictly above the target and at or below its start.
    `LBFPH_ASSERT_SAME(a_fall_above_target, aclk, aresetn, anim_active_reg,
        (anim_position_reg > anim_target_reg) && (anim_position_reg <= anim_start_reg))
    // The peak marker never sits below the bar.
    `LBFPH_ASSERT_SAME(a_peak_over_bar, aclk, aresetn, 1'b1, peak_reg >= bar_reg)
    // A result taken while nothing advances leaves the output stage empty.
    `LBFPH_ASSERT_NEXT(a_out_drains, aclk, aresetn,
        m_axis_tvalid && m_axis_tready && !s2_valid_reg, !m_axis_tvalid)

endmodule
